// ----- sv/lbc_pkg.sv -----
package lbc_pkg;

  localparam int COORD_BITS      = 16;
  localparam int T_FRACTION_BITS = 16;

  // edge deltas and t numerators need one bit more than a coordinate
  localparam int DW        = COORD_BITS + 1;
  localparam int TW        = COORD_BITS + T_FRACTION_BITS + 2;
  localparam int CTW       = T_FRACTION_BITS + 2;
  localparam int PW        = CTW + DW;
  localparam int DIV_STEPS = (COORD_BITS + T_FRACTION_BITS + 1) / 2;
  localparam int DVD_W     = 2 * DIV_STEPS;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         delta_t;
  typedef logic signed [TW-1:0]         tpar_t;
  typedef logic signed [CTW-1:0]        tclamp_t;
  typedef logic signed [PW-1:0]         prod_t;

  localparam tpar_t T_ONE = TW'(64'd1 << T_FRACTION_BITS);
  localparam tpar_t T_INF = TW'((64'd1 << (COORD_BITS + T_FRACTION_BITS)) - 64'd1);
  localparam prod_t RND_BIAS = PW'((64'd1 << T_FRACTION_BITS) - 64'd1);

  localparam logic [1:0] CFG_LEFT   = 2'd0;
  localparam logic [1:0] CFG_BOTTOM = 2'd1;
  localparam logic [1:0] CFG_RIGHT  = 2'd2;
  localparam logic [1:0] CFG_TOP    = 2'd3;

  localparam logic [1:0] T_INX  = 2'd0;
  localparam logic [1:0] T_INY  = 2'd1;
  localparam logic [1:0] T_OUTX = 2'd2;
  localparam logic [1:0] T_OUTY = 2'd3;

  typedef struct packed {
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
  } window_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    logic   has_edge;
    logic   closing;
  } edge_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_DSTART,
    S_DWAIT,
    S_CHK1,
    S_CORNER1,
    S_CHK1B,
    S_CHK2,
    S_ENT_MUL,
    S_ENT_EMIT,
    S_EXT_MUL,
    S_EXT_EMIT,
    S_END_EMIT,
    S_CORNER2,
    S_FIN,
    S_CLOSE
  } state_t;

  function automatic tclamp_t clamp_t(tpar_t t);
    tclamp_t r;
    if (t < 0) r = '0;
    else if (t > T_ONE) r = CTW'(T_ONE);
    else r = t[CTW-1:0];
    return r;
  endfunction

  // base + product / 2^F, truncated toward zero
  function automatic coord_t lerp_fin(coord_t base, prod_t p);
    prod_t q;
    if (p < 0) q = (p + RND_BIAS) >>> T_FRACTION_BITS;
    else q = p >>> T_FRACTION_BITS;
    return base + coord_t'(q[COORD_BITS-1:0]);
  endfunction

endpackage

// ----- sv/liang_barsky_polygon_clip_top.sv -----
// channel  dir  handshake             payload
// in       in   in_valid/in_ready     in_vertex_x, in_vertex_y, in_is_closing
// out      out  out_valid/out_ready   out_point_x, out_point_y, out_point_valid,
//                                     out_end_of_polygon
// cfg      in   cfg_wr_en             cfg_index, cfg_data
//
// a vertex that closes an edge is worked in the back end through the shared
// radix-4 divider, which works out up to four t per edge, one at a time; an
// axis-parallel t takes a sentinel instead, and a close with no edge before it skips the divider
// the front takes a vertex per cycle while the two-entry edge queue has room
// synchronous active-low reset clears the queue, sequencer and polygon state
// output stalls hold the sequencer at its next point, never the divider

module liang_barsky_polygon_clip_top
  import lbc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  coord_t       in_vertex_x,
  input  coord_t       in_vertex_y,
  input  logic         in_is_closing,
  output logic         out_valid,
  input  logic         out_ready,
  output coord_t       out_point_x,
  output coord_t       out_point_y,
  output logic         out_point_valid,
  output logic         out_end_of_polygon,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  coord_t       cfg_data
);

  window_t    win_r;
  fifo_stat_t fifo_stat;
  logic       push, pop;
  edge_t      push_edge, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.left   <= '0;
      win_r.bottom <= '0;
      win_r.right  <= coord_t'(32767);
      win_r.top    <= coord_t'(32767);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LEFT:   win_r.left   <= cfg_data;
        CFG_BOTTOM: win_r.bottom <= cfg_data;
        CFG_RIGHT:  win_r.right  <= cfg_data;
        CFG_TOP:    win_r.top    <= cfg_data;
        default:    ;
      endcase
    end
  end

  lbc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_vertex_x   (in_vertex_x),
    .in_vertex_y   (in_vertex_y),
    .in_is_closing (in_is_closing),
    .fifo_stat     (fifo_stat),
    .push          (push),
    .push_edge     (push_edge)
  );

  lbc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_edge (push_edge),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  lbc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .win                (win_r),
    .head               (head),
    .fifo_stat          (fifo_stat),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_point_x        (out_point_x),
    .out_point_y        (out_point_y),
    .out_point_valid    (out_point_valid),
    .out_end_of_polygon (out_end_of_polygon)
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("edge queue both full and empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_stat.full |-> !push)
    else $error("push into full edge queue");

  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_point_valid) |->
      (out_end_of_polygon && out_point_x == 0 && out_point_y == 0))
    else $error("invalid point that is not the empty-polygon marker");

endmodule

// ----- sv/lbc_front.sv -----
module lbc_front
  import lbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  coord_t     in_vertex_x,
  input  coord_t     in_vertex_y,
  input  logic       in_is_closing,
  input  fifo_stat_t fifo_stat,
  output logic       push,
  output edge_t      push_edge
);

  coord_t prev_x_r, prev_y_r;
  logic   have_prev_r;
  logic   accept;

  assign in_ready = !fifo_stat.full;
  assign accept   = in_valid && in_ready;

  // a first vertex that is not closing produces nothing, so it never enters the queue
  assign push = accept && (have_prev_r || in_is_closing);
  assign push_edge = '{x1: prev_x_r, y1: prev_y_r, x2: in_vertex_x, y2: in_vertex_y,
                       has_edge: have_prev_r, closing: in_is_closing};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
    end else if (accept) begin
      prev_x_r    <= in_vertex_x;
      prev_y_r    <= in_vertex_y;
      have_prev_r <= !in_is_closing;
    end
  end

endmodule

// ----- sv/lbc_fifo.sv -----
module lbc_fifo
  import lbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  edge_t      push_edge,
  input  logic       pop,
  output edge_t      head,
  output fifo_stat_t stat
);

  edge_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_edge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- sv/lbc_div.sv -----
module lbc_div
  import lbc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  delta_t num,
  input  delta_t den,
  output logic   done,
  output tpar_t  q
);

  logic              busy_r, done_r, neg_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DW-1:0]     rem_r, dvs_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DW-1:0]     rem_nxt;
  logic [DVD_W-1:0]  quo_nxt;
  logic [DW-1:0]     num_mag, den_mag;
  tpar_t             mag;

  assign num_mag = (num < 0) ? DW'(-num) : DW'(num);
  assign den_mag = (den < 0) ? DW'(-den) : DW'(den);

  // two restoring steps per cycle
  always_comb begin
    logic [DW:0] trial;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < 2; i++) begin
      trial   = {rem_nxt, quo_nxt[DVD_W-1]};
      quo_nxt = quo_nxt << 1;
      if (trial >= {1'b0, dvs_r}) begin
        trial      = trial - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DW-1:0];
    end
  end

  // |num| < 2^COORD_BITS, so the quotient never reaches the sentinel
  assign mag  = TW'(quo_r);
  assign q    = neg_r ? -mag : mag;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= den_mag;
      neg_r <= (num < 0) ^ (den < 0);
      quo_r <= DVD_W'(num_mag) << T_FRACTION_BITS;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule

// ----- sv/lbc_back.sv -----
module lbc_back
  import lbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  window_t    win,
  input  edge_t      head,
  input  fifo_stat_t fifo_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output coord_t     out_point_x,
  output coord_t     out_point_y,
  output logic       out_point_valid,
  output logic       out_end_of_polygon
);

  state_t state_r, state_nxt;
  edge_t  e_r, e_nxt;
  delta_t dx_r, dx_nxt, dy_r, dy_nxt;
  coord_t xin_r, xin_nxt, xout_r, xout_nxt, yin_r, yin_nxt, yout_r, yout_nxt;
  tpar_t  tinx_r, tinx_nxt, tiny_r, tiny_nxt, toutx_r, toutx_nxt, touty_r, touty_nxt;
  logic [1:0] dsel_r, dsel_nxt;
  prod_t  prod_r, prod_nxt;
  logic   produced_r, produced_nxt;
  coord_t first_x_r, first_x_nxt, first_y_r, first_y_nxt;

  logic   out_valid_r, out_pv_r, out_last_r;
  coord_t out_x_r, out_y_r;

  logic   emit_v, emit_pv, emit_last;
  coord_t emit_x, emit_y;
  logic   out_free;

  logic   div_start, div_done;
  delta_t div_num, div_den;
  tpar_t  div_q, sentinel;
  tpar_t  tin1, tin2, tout1;
  delta_t sdx, sdy;

  lbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  assign out_free = !out_valid_r || out_ready;
  assign tin1  = (tinx_r < tiny_r) ? tinx_r : tiny_r;
  assign tin2  = (tinx_r < tiny_r) ? tiny_r : tinx_r;
  assign tout1 = (toutx_r < touty_r) ? toutx_r : touty_r;
  assign sdx   = delta_t'(e_r.x2) - delta_t'(e_r.x1);
  assign sdy   = delta_t'(e_r.y2) - delta_t'(e_r.y1);

  // operands for the current t; axis-parallel edges take a sentinel
  always_comb begin
    case (dsel_r)
      T_INX: begin
        div_num  = delta_t'(xin_r) - delta_t'(e_r.x1);
        div_den  = dx_r;
        sentinel = -T_INF;
      end
      T_INY: begin
        div_num  = delta_t'(yin_r) - delta_t'(e_r.y1);
        div_den  = dy_r;
        sentinel = -T_INF;
      end
      T_OUTX: begin
        div_num  = delta_t'(xout_r) - delta_t'(e_r.x1);
        div_den  = dx_r;
        sentinel = (win.left <= e_r.x1 && e_r.x1 <= win.right) ? T_INF : -T_INF;
      end
      default: begin
        div_num  = delta_t'(yout_r) - delta_t'(e_r.y1);
        div_den  = dy_r;
        sentinel = (win.bottom <= e_r.y1 && e_r.y1 <= win.top) ? T_INF : -T_INF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      produced_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      produced_r <= produced_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r       <= e_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    xin_r     <= xin_nxt;
    xout_r    <= xout_nxt;
    yin_r     <= yin_nxt;
    yout_r    <= yout_nxt;
    tinx_r    <= tinx_nxt;
    tiny_r    <= tiny_nxt;
    toutx_r   <= toutx_nxt;
    touty_r   <= touty_nxt;
    dsel_r    <= dsel_nxt;
    prod_r    <= prod_nxt;
    first_x_r <= first_x_nxt;
    first_y_r <= first_y_nxt;
  end

  always_comb begin
    tpar_t  tval;
    state_t after_t;
    state_nxt    = state_r;
    e_nxt        = e_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    xin_nxt      = xin_r;
    xout_nxt     = xout_r;
    yin_nxt      = yin_r;
    yout_nxt     = yout_r;
    tinx_nxt     = tinx_r;
    tiny_nxt     = tiny_r;
    toutx_nxt    = toutx_r;
    touty_nxt    = touty_r;
    dsel_nxt     = dsel_r;
    prod_nxt     = prod_r;
    produced_nxt = produced_r;
    first_x_nxt  = first_x_r;
    first_y_nxt  = first_y_r;
    pop          = 1'b0;
    div_start    = 1'b0;
    emit_v       = 1'b0;
    emit_pv      = 1'b1;
    emit_last    = 1'b0;
    emit_x       = '0;
    emit_y       = '0;
    tval         = div_q;
    after_t      = S_DSTART;

    case (state_r)
      S_IDLE: begin
        if (!fifo_stat.empty) begin
          pop       = 1'b1;
          e_nxt     = head;
          state_nxt = head.has_edge ? S_SETUP : S_CLOSE;
        end
      end
      S_SETUP: begin
        dx_nxt = sdx;
        dy_nxt = sdy;
        if (sdx > 0 || (sdx == 0 && e_r.x1 > win.right)) begin
          xin_nxt  = win.left;
          xout_nxt = win.right;
        end else begin
          xin_nxt  = win.right;
          xout_nxt = win.left;
        end
        if (sdy > 0 || (sdy == 0 && e_r.y1 > win.top)) begin
          yin_nxt  = win.bottom;
          yout_nxt = win.top;
        end else begin
          yin_nxt  = win.top;
          yout_nxt = win.bottom;
        end
        dsel_nxt  = T_INX;
        state_nxt = S_DSTART;
      end
      S_DSTART, S_DWAIT: begin
        if (dsel_r == T_INY) after_t = S_CHK1;
        else if (dsel_r == T_OUTY) after_t = S_CHK2;
        if (state_r == S_DSTART && div_den != 0) begin
          div_start = 1'b1;
          state_nxt = S_DWAIT;
        end else if (state_r == S_DSTART || div_done) begin
          if (state_r == S_DSTART) tval = sentinel;
          case (dsel_r)
            T_INX:   tinx_nxt  = tval;
            T_INY:   tiny_nxt  = tval;
            T_OUTX:  toutx_nxt = tval;
            default: touty_nxt = tval;
          endcase
          dsel_nxt  = dsel_r + 2'd1;
          state_nxt = after_t;
        end
      end
      S_CHK1: begin
        if (tin1 > T_ONE) state_nxt = S_FIN;
        else if (tin1 > 0) state_nxt = S_CORNER1;
        else state_nxt = S_CHK1B;
      end
      S_CORNER1: begin
        if (out_free) begin
          emit_v    = 1'b1;
          emit_x    = xin_r;
          emit_y    = yin_r;
          state_nxt = S_CHK1B;
        end
      end
      S_CHK1B: begin
        if (tin2 > T_ONE) begin
          state_nxt = S_FIN;
        end else begin
          dsel_nxt  = T_OUTX;
          state_nxt = S_DSTART;
        end
      end
      S_CHK2: begin
        if (!(tin2 > 0 || tout1 > 0)) state_nxt = S_FIN;
        else if (tin2 > tout1) state_nxt = S_CORNER2;
        else if (tin2 > 0) state_nxt = S_ENT_MUL;
        else if (tout1 < T_ONE) state_nxt = S_EXT_MUL;
        else state_nxt = S_END_EMIT;
      end
      S_ENT_MUL: begin
        if (tinx_r > tiny_r) prod_nxt = prod_t'(clamp_t(tinx_r)) * prod_t'(dy_r);
        else prod_nxt = prod_t'(clamp_t(tiny_r)) * prod_t'(dx_r);
        state_nxt = S_ENT_EMIT;
      end
      S_ENT_EMIT: begin
        if (out_free) begin
          emit_v = 1'b1;
          if (tinx_r > tiny_r) begin
            emit_x = xin_r;
            emit_y = lerp_fin(e_r.y1, prod_r);
          end else begin
            emit_x = lerp_fin(e_r.x1, prod_r);
            emit_y = yin_r;
          end
          state_nxt = (tout1 < T_ONE) ? S_EXT_MUL : S_END_EMIT;
        end
      end
      S_EXT_MUL: begin
        if (toutx_r < touty_r) prod_nxt = prod_t'(clamp_t(toutx_r)) * prod_t'(dy_r);
        else prod_nxt = prod_t'(clamp_t(touty_r)) * prod_t'(dx_r);
        state_nxt = S_EXT_EMIT;
      end
      S_EXT_EMIT: begin
        if (out_free) begin
          emit_v = 1'b1;
          if (toutx_r < touty_r) begin
            emit_x = xout_r;
            emit_y = lerp_fin(e_r.y1, prod_r);
          end else begin
            emit_x = lerp_fin(e_r.x1, prod_r);
            emit_y = yout_r;
          end
          state_nxt = S_FIN;
        end
      end
      S_END_EMIT: begin
        if (out_free) begin
          emit_v    = 1'b1;
          emit_x    = e_r.x2;
          emit_y    = e_r.y2;
          state_nxt = S_FIN;
        end
      end
      S_CORNER2: begin
        if (out_free) begin
          emit_v = 1'b1;
          if (tinx_r > tiny_r) begin
            emit_x = xin_r;
            emit_y = yout_r;
          end else begin
            emit_x = xout_r;
            emit_y = yin_r;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = e_r.closing ? S_CLOSE : S_IDLE;
      end
      S_CLOSE: begin
        if (out_free) begin
          emit_v    = 1'b1;
          emit_last = 1'b1;
          emit_pv   = produced_r;
          emit_x    = produced_r ? first_x_r : '0;
          emit_y    = produced_r ? first_y_r : '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // remember the first point of the polygon
    if (emit_v && !emit_last && !produced_r) begin
      produced_nxt = 1'b1;
      first_x_nxt  = emit_x;
      first_y_nxt  = emit_y;
    end
    if (emit_v && emit_last) produced_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_v) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_v) begin
      out_x_r    <= emit_x;
      out_y_r    <= emit_y;
      out_pv_r   <= emit_pv;
      out_last_r <= emit_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_point_x        = out_x_r;
  assign out_point_y        = out_y_r;
  assign out_point_valid    = out_pv_r;
  assign out_end_of_polygon = out_last_r;

endmodule
